[hw/rtl/dotq_pkg.sv]
// Shared types and codes for the deadline ordered task queue.
// No dependencies; used by dotq_cell and deadline_ordered_task_queue.
package dotq_pkg;

  localparam int unsigned QueueDepth = 16;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] task_id;
    logic [63:0] deadline;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] task_out;
    logic [63:0] deadline_out;
    logic        found;
    logic [63:0] head_deadline;
    logic        head_valid;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] task_id;
    logic [63:0] deadline;
  } entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [15:0] task_id;
    logic [63:0] deadline;
  } cell_ctrl_t;

endpackage

[hw/rtl/dotq_cell.sv]
// One slot of the sorted queue: holds an entry, shifts toward the tail on
// push and toward the head on pop. Depends on dotq_pkg.
module dotq_cell (
  input  logic                clk,
  input  logic                rst,
  input  dotq_pkg::cell_ctrl_t ctrl,
  input  dotq_pkg::entry_t    left,
  input  logic                left_place,
  input  dotq_pkg::entry_t    right,
  output dotq_pkg::entry_t    entry,
  output logic                place,
  output logic                hit
);

  dotq_pkg::entry_t entry_next;

  assign place = !entry.valid || (ctrl.deadline < entry.deadline);
  assign hit   = entry.valid && (entry.task_id == ctrl.task_id);

  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (left_place) begin
        entry_next = left;
      end else if (place) begin
        entry_next.valid    = 1'b1;
        entry_next.task_id  = ctrl.task_id;
        entry_next.deadline = ctrl.deadline;
      end
    end else if (ctrl.pop) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry.task_id  <= entry_next.task_id;
    entry.deadline <= entry_next.deadline;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

[hw/rtl/deadline_ordered_task_queue.sv]
// Top level of the deadline ordered task queue: a row of dotq_cell slots
// plus the result register. Depends on dotq_pkg and dotq_cell.
//
// Usage: the cmd channel carries one beat per operation (push, pop or
// query); the res channel returns exactly one beat per cmd beat, in order.
// Each beat is taken when valid is high and stall is low.
// The result is registered and appears in the cycle after cmd is taken.
// Throughput: one cmd beat per cycle while cmd_stall is low; every cell
// compares its deadline with the pushed one and moves its entry in that
// same cycle, so the row settles push, pop and query as the beat is taken.
// The result register sits between the channels: a new cmd beat is taken
// while the pending result is taken in the same cycle. When the receiver
// stalls, the result holds and cmd_stall rises until the result leaves.
// Reset empties the queue and drops any pending result; the queue is
// ready as soon as reset is released.
// head_deadline and head_valid report the queue head after the operation.
module deadline_ordered_task_queue #(
  parameter int unsigned QUEUE_DEPTH = dotq_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  dotq_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output dotq_pkg::res_t res
);

  dotq_pkg::entry_t     ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] place;
  logic [QUEUE_DEPTH-1:0] hit;
  dotq_pkg::cell_ctrl_t ctrl;
  dotq_pkg::entry_t     empty_entry;
  logic                 accept;
  logic                 full;
  logic                 empty;

  logic [1:0]  status;
  logic [15:0] task_out;
  logic [63:0] deadline_out;
  logic        found;

  assign cmd_stall   = res_valid && res_stall;
  assign accept      = cmd_valid && !cmd_stall;
  assign full        = ent[QUEUE_DEPTH-1].valid;
  assign empty       = !ent[0].valid;
  assign empty_entry = '0;

  assign ctrl.push     = accept && (cmd.opcode == dotq_pkg::OP_PUSH) && !full;
  assign ctrl.pop      = accept && (cmd.opcode == dotq_pkg::OP_POP);
  assign ctrl.task_id  = cmd.task_id;
  assign ctrl.deadline = cmd.deadline;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dotq_pkg::entry_t left_ent;
    dotq_pkg::entry_t right_ent;
    logic             left_pl;
    if (i == 0) begin : g_first
      assign left_ent = empty_entry;
      assign left_pl  = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_pl  = place[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = empty_entry;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end
    dotq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left       (left_ent),
      .left_place (left_pl),
      .right      (right_ent),
      .entry      (ent[i]),
      .place      (place[i]),
      .hit        (hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= dotq_pkg::ST_OK;
      task_out     <= '0;
      deadline_out <= '0;
      found        <= 1'b0;
      unique case (cmd.opcode)
        dotq_pkg::OP_PUSH: begin
          if (full) begin
            status <= dotq_pkg::ST_FULL;
          end
        end
        dotq_pkg::OP_POP: begin
          if (empty) begin
            status <= dotq_pkg::ST_EMPTY;
          end else begin
            task_out     <= ent[0].task_id;
            deadline_out <= ent[0].deadline;
          end
        end
        dotq_pkg::OP_QUERY: begin
          found <= |hit;
        end
        default: begin
        end
      endcase
    end
  end

  assign res.status        = status;
  assign res.task_out      = task_out;
  assign res.deadline_out  = deadline_out;
  assign res.found         = found;
  assign res.head_valid    = ent[0].valid;
  assign res.head_deadline = ent[0].valid ? ent[0].deadline : 64'd0;

endmodule

[test/tb_deadline_ordered_task_queue.sv]
// Testbench for deadline_ordered_task_queue: directed and random push, pop, query and no-op
// beats, every result checked against a local sorted-queue predictor.
// Depends on dotq_pkg and the deadline_ordered_task_queue RTL.
module tb_deadline_ordered_task_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int Depth = dotq_pkg::QueueDepth;
  localparam int RandomOps = 1850;

  typedef struct packed {
    logic wait_drain;
    dotq_pkg::cmd_t op;
  } queued_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  dotq_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  dotq_pkg::res_t res;

  deadline_ordered_task_queue uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #5 clk = ~clk;

  logic [63:0] sorted_deadline [Depth];
  logic [15:0] sorted_task [Depth];
  int held_count = 0;
  dotq_pkg::res_t expected_res [$];
  queued_cmd_t cmd_backlog [$];
  dotq_pkg::res_t want;
  queued_cmd_t next_beat;
  bit cmd_taken = 1'b0;
  int total_ops = 0;
  int ops_accepted = 0;
  int fail_count = 0;
  int n_push = 0, n_full = 0, n_pop = 0, n_empty = 0;
  int n_query = 0, n_hit = 0, n_nop = 0, peak_count = 0;
  int burst_left = 1, gap_left = 0;
  int stall_mode = 0, stall_run = 0;

  function automatic dotq_pkg::res_t apply_queue_op(dotq_pkg::cmd_t c);
    dotq_pkg::res_t r;
    int slot;
    r = '0;
    case (c.opcode)
      dotq_pkg::OP_PUSH: begin
        n_push++;
        if (held_count >= Depth) begin
          r.status = dotq_pkg::ST_FULL;
          n_full++;
        end else begin
          slot = held_count;
          while (slot > 0 && c.deadline < sorted_deadline[slot-1]) begin
            sorted_deadline[slot] = sorted_deadline[slot-1];
            sorted_task[slot] = sorted_task[slot-1];
            slot--;
          end
          sorted_deadline[slot] = c.deadline;
          sorted_task[slot] = c.task_id;
          held_count++;
          if (held_count > peak_count) peak_count = held_count;
        end
      end
      dotq_pkg::OP_POP: begin
        n_pop++;
        if (held_count == 0) begin
          r.status = dotq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.task_out = sorted_task[0];
          r.deadline_out = sorted_deadline[0];
          for (int i = 1; i < held_count; i++) begin
            sorted_deadline[i-1] = sorted_deadline[i];
            sorted_task[i-1] = sorted_task[i];
          end
          held_count--;
        end
      end
      dotq_pkg::OP_QUERY: begin
        n_query++;
        for (int i = 0; i < held_count; i++) begin
          if (sorted_task[i] == c.task_id) r.found = 1'b1;
        end
        if (r.found) n_hit++;
      end
      default: begin
        n_nop++;
      end
    endcase
    r.head_valid = held_count > 0;
    r.head_deadline = (held_count > 0) ? sorted_deadline[0] : 64'd0;
    return r;
  endfunction

  function automatic void enqueue_op(logic [1:0] opc, logic [15:0] id, logic [63:0] dl,
                                     bit drain);
    queued_cmd_t q;
    q.wait_drain = drain;
    q.op.opcode = opc;
    q.op.task_id = id;
    q.op.deadline = dl;
    cmd_backlog.push_back(q);
    total_ops++;
  endfunction

  // Driver: record the accepted beat, then advance at the falling edge.
  always @(posedge clk) begin
    cmd_taken = !rst && cmd_valid && !cmd_stall;
    if (cmd_taken) begin
      expected_res.push_back(apply_queue_op(cmd));
      ops_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() == 0 ||
                   (cmd_backlog[0].wait_drain && expected_res.size() != 0)) begin
        cmd_valid <= 1'b0;
      end else begin
        next_beat = cmd_backlog.pop_front();
        cmd <= next_beat.op;
        cmd_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(4, 64);
    end
    stall_run--;
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= 1'($urandom_range(0, 1));
      2: res_stall <= ($urandom_range(0, 4) != 0);
      default: res_stall <= (stall_run % 8) < 5;
    endcase
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_res.size() == 0) begin
        $error("result beat with no operation outstanding");
        fail_count++;
      end else begin
        want = expected_res.pop_front();
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          fail_count++;
        end
        if (res.task_out !== want.task_out) begin
          $error("task_out: expected %h, got %h", want.task_out, res.task_out);
          fail_count++;
        end
        if (res.deadline_out !== want.deadline_out) begin
          $error("deadline_out: expected %h, got %h", want.deadline_out, res.deadline_out);
          fail_count++;
        end
        if (res.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, res.found);
          fail_count++;
        end
        if (res.head_deadline !== want.head_deadline) begin
          $error("head_deadline: expected %h, got %h", want.head_deadline, res.head_deadline);
          fail_count++;
        end
        if (res.head_valid !== want.head_valid) begin
          $error("head_valid: expected %0d, got %0d", want.head_valid, res.head_valid);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int phase_len;
    int push_pct;
    int roll;
    logic [1:0] opc;
    logic [15:0] id;
    logic [63:0] dl;

    enqueue_op(dotq_pkg::OP_POP, 16'h0000, 64'd0, 1'b0);
    enqueue_op(dotq_pkg::OP_QUERY, 16'h0000, 64'd0, 1'b0);
    enqueue_op(OP_NOP, 16'hFFFF, '1, 1'b0);
    enqueue_op(dotq_pkg::OP_PUSH, 16'hFFFF, '1, 1'b0);
    enqueue_op(dotq_pkg::OP_PUSH, 16'h0000, 64'd0, 1'b0);
    enqueue_op(dotq_pkg::OP_PUSH, 16'h1234, 64'd100, 1'b0);
    enqueue_op(dotq_pkg::OP_PUSH, 16'h5678, 64'd100, 1'b0);
    enqueue_op(dotq_pkg::OP_QUERY, 16'h0000, '1, 1'b0);
    enqueue_op(dotq_pkg::OP_QUERY, 16'h0001, 64'd0, 1'b0);
    for (int k = 0; k < Depth - 4; k++) begin
      enqueue_op(dotq_pkg::OP_PUSH, 16'(16'h0100 + k), 64'(50 + (k % 3) * 50), 1'b0);
    end
    enqueue_op(dotq_pkg::OP_PUSH, 16'hABCD, 64'd1, 1'b0);
    enqueue_op(dotq_pkg::OP_QUERY, 16'hFFFF, 64'd0, 1'b0);
    repeat (3) enqueue_op(dotq_pkg::OP_POP, 16'hFFFF, '1, 1'b0);

    while (total_ops < 26 + RandomOps) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 20;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      for (int k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) opc = OP_NOP;
        else if (roll < push_pct) opc = dotq_pkg::OP_PUSH;
        else if (roll < push_pct + (100 - push_pct) / 2) opc = dotq_pkg::OP_POP;
        else opc = dotq_pkg::OP_QUERY;
        id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 23));
        case ($urandom_range(0, 9))
          0: dl = 64'd0;
          1: dl = '1;
          2: dl = '1 - 64'($urandom_range(0, 3));
          3, 4: dl = {$urandom, $urandom};
          default: dl = 64'($urandom_range(0, 20));
        endcase
        enqueue_op(opc, id, dl, (k == 0 && total_ops == 26) || $urandom_range(0, 299) == 0);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (ops_accepted != total_ops || expected_res.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d operations: %0d pushes (%0d refused full), %0d pops (%0d on empty),",
             ops_accepted, n_push, n_full, n_pop, n_empty);
    $display("%0d queries (%0d hits), %0d no-ops; peak occupancy %0d of %0d",
             n_query, n_hit, n_nop, peak_count, Depth);
    if (fail_count == 0 && expected_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $error("timeout: %0d of %0d operations accepted, %0d results outstanding",
           ops_accepted, total_ops, expected_res.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
